FILE: hw/rtl/pls_pkg.sv
package pls_pkg;

	// List geometry
	localparam int DEPTH = 16;
	localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW  = $clog2(DEPTH + 1);

	// Field widths
	localparam int OpW   = 2;
	localparam int PosW  = 5;
	localparam int WordW = 32;
	localparam int StW   = 2;
	localparam int CapW  = 5;

	localparam logic [CapW-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic [OpW-1:0] OP_APPEND = 2'd0;
	localparam logic [OpW-1:0] OP_INSERT = 2'd1;
	localparam logic [OpW-1:0] OP_DELETE = 2'd2;
	localparam logic [OpW-1:0] OP_DUMP   = 2'd3;

	// Status codes
	localparam logic [StW-1:0] ST_OK     = 2'd0;
	localparam logic [StW-1:0] ST_FULL   = 2'd1;
	localparam logic [StW-1:0] ST_EMPTY  = 2'd2;
	localparam logic [StW-1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [OpW-1:0]          operation;
		logic [PosW-1:0]         position;
		logic signed [WordW-1:0] value;
	} pls_req_t;

	typedef struct packed {
		logic [StW-1:0]          status;
		logic signed [WordW-1:0] data_word;
		logic [4:0]              entry_count;
		logic                    last_of_run;
	} pls_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic           append;
		logic           insert;
		logic           remove;
		logic           emit;
		logic [StW-1:0] status;
		logic           word_sel;
		logic           last;
		logic           idx_clr;
		logic           idx_inc;
	} pls_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_pos_ok;
		logic del_pos_ok;
		logic idx_last;
	} pls_flags_t;

endpackage

FILE: hw/rtl/positional_list_store.sv
// Positional list store: an ordered list of up to 16 signed 32-bit words.
// Request channel: when start is high and busy is low, the request on
// request (operation, position, value) is taken at that clock edge.
// Operations: append, insert at a one-based position, delete at a position
// (returns the removed word), and dump of every stored word in order.
// Result channel: each result sits on result for exactly one cycle with
// result_valid high; the receiver cannot stall, so results are never held.
// Append, insert and delete give one result in the cycle after the request
// and keep busy low, so one request per cycle is taken while no dump runs.
// Dump of n entries gives n results on consecutive cycles, the first
// coming through the dump state and then the result register, the last one
// flagged by last_of_run; busy is high while the dump index walks the cells.
// A dump of an empty list gives a single empty-status result.
// Configuration: cfg_we writes cfg_wdata into the capacity register; write
// it only while the block is idle.
// Reset (arst_n low) empties the list and sets the capacity to 16; the
// stored words themselves are not cleared.
module positional_list_store import pls_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pls_req_t        request,
	output logic            busy,
	input  logic            cfg_we,
	input  logic [CapW-1:0] cfg_wdata,
	output logic            result_valid,
	output pls_rsp_t        result
);

	pls_cmd_t   cmd;
	pls_flags_t flags;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.flags     (flags),
		.busy      (busy),
		.cmd       (cmd)
	);

	pls_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.flags        (flags),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: hw/rtl/pls_ctrl.sv
module pls_ctrl import pls_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [OpW-1:0] operation,
	input  pls_flags_t     flags,
	output logic           busy,
	output pls_cmd_t       cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign busy   = (state_q == S_DUMP);
	assign accept = start && !busy;

	// Decode the request and walk the dump
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.last = 1'b1;
					unique case (operation)
						OP_APPEND: begin
							cmd.emit = 1'b1;
							if (flags.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.append = 1'b1;
								cmd.status = ST_OK;
							end
						end
						OP_INSERT: begin
							cmd.emit = 1'b1;
							priority if (flags.full) begin
								cmd.status = ST_FULL;
							end else if (!flags.ins_pos_ok) begin
								cmd.status = ST_BADPOS;
							end else begin
								cmd.insert = 1'b1;
								cmd.status = ST_OK;
							end
						end
						OP_DELETE: begin
							cmd.emit = 1'b1;
							priority if (flags.empty) begin
								cmd.status = ST_EMPTY;
							end else if (!flags.del_pos_ok) begin
								cmd.status = ST_BADPOS;
							end else begin
								cmd.remove   = 1'b1;
								cmd.word_sel = 1'b1;
								cmd.status   = ST_OK;
							end
						end
						OP_DUMP: begin
							if (flags.empty) begin
								cmd.emit   = 1'b1;
								cmd.status = ST_EMPTY;
							end else begin
								cmd.last    = 1'b0;
								cmd.idx_clr = 1'b1;
								state_d     = S_DUMP;
							end
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			S_DUMP: begin
				cmd.emit     = 1'b1;
				cmd.status   = ST_OK;
				cmd.word_sel = 1'b1;
				cmd.idx_inc  = 1'b1;
				cmd.last     = flags.idx_last;
				if (flags.idx_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) && flags.idx_last |=> (state_q == S_IDLE))
		else $error("dump did not end after the last entry");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.append, cmd.insert, cmd.remove}))
		else $error("more than one list update in a cycle");
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.append || cmd.insert || cmd.remove))
		else $error("list update while dumping");
`endif

endmodule

FILE: hw/rtl/pls_datapath.sv
module pls_datapath import pls_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  pls_req_t        request,
	input  pls_cmd_t        cmd,
	input  logic            cfg_we,
	input  logic [CapW-1:0] cfg_wdata,
	output pls_flags_t      flags,
	output logic            result_valid,
	output pls_rsp_t        result
);

	localparam int CmpW = ((CntW > CapW) ? CntW : CapW) + 1;

	logic [WordW-1:0] cells_q [DEPTH];
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_d;
	logic [CapW-1:0]  cap_q;
	logic [IdxW-1:0]  idx_q;
	logic [IdxW-1:0]  pos_idx;
	logic [IdxW-1:0]  rd_idx;
	logic [WordW-1:0] rd_word;
	logic [CmpW-1:0]  eff_cap;
	logic             result_valid_q;
	pls_rsp_t         result_q;

	assign pos_idx = IdxW'(request.position - 5'd1);

	// Shift cells: each takes the request word, a neighbor, or holds
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WordW-1:0] from_below;
		logic [WordW-1:0] from_above;
		if (g == 0) begin : g_first
			assign from_below = '0;
		end else begin : g_lower
			assign from_below = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_top
			assign from_above = cells_q[g];
		end else begin : g_upper
			assign from_above = cells_q[g+1];
		end
		always_ff @(posedge clk) begin
			priority if (cmd.append && (CntW'(g) == count_q)) begin
				cells_q[g] <= request.value;
			end else if (cmd.insert && (IdxW'(g) == pos_idx)) begin
				cells_q[g] <= request.value;
			end else if (cmd.insert && (IdxW'(g) > pos_idx)) begin
				cells_q[g] <= from_below;
			end else if (cmd.remove && (IdxW'(g) >= pos_idx)) begin
				cells_q[g] <= from_above;
			end
		end
	end

	// Read one cell: dump index or request position
	assign rd_idx  = cmd.idx_inc ? idx_q : pos_idx;
	assign rd_word = cells_q[rd_idx];

	// Advance the entry count
	always_comb begin
		priority if (cmd.append || cmd.insert) begin
			count_d = count_q + CntW'(1);
		end else if (cmd.remove) begin
			count_d = count_q - CntW'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			idx_q   <= '0;
		end else begin
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	// Status toward the controller
	assign eff_cap = (CmpW'(cap_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_q);
	assign flags.full       = CmpW'(count_q) >= eff_cap;
	assign flags.empty      = (count_q == '0);
	assign flags.ins_pos_ok = (request.position != '0) &&
		(CmpW'(request.position) <= CmpW'(count_q) + CmpW'(1));
	assign flags.del_pos_ok = (request.position != '0) &&
		(CmpW'(request.position) <= CmpW'(count_q));
	assign flags.idx_last   = ((CntW'(idx_q) + CntW'(1)) == count_q);

	// Register the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.status      <= cmd.status;
			result_q.data_word   <= cmd.word_sel ? rd_word : '0;
			result_q.entry_count <= 5'(count_d);
			result_q.last_of_run <= cmd.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(count_q) <= CmpW'(DEPTH))
		else $error("entry count above store depth");
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("append did not grow the list");
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |-> !flags.empty && flags.del_pos_ok)
		else $error("delete on empty list or bad position");
`endif

endmodule
